@@ rtl/core/hcbd_pkg.sv @@
// Shared constants, types and helpers of the HTTP chunked body decoder.
package hcbd_pkg;

  localparam int unsigned SIZE_BITS = 40;

  // decoder phases
  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_CEND  = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'd0;
    ok = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d  = c - CH_ZERO;
      ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      d  = c - CH_LA + HEX_TEN;
      ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d  = c - CH_UA + HEX_TEN;
      ok = 1'b1;
    end
    return {ok, d[3:0]};
  endfunction

endpackage

@@ rtl/core/hcbd_step.sv @@
// Decoder state and the per-byte next-state and result logic.
module hcbd_step (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [7:0]              in_byte_i,
  input  logic                    new_body_i,
  output hcbd_pkg::result_t       res_o
);

  logic [2:0]                     phase_q, phase_d;
  logic [hcbd_pkg::SIZE_BITS-1:0] rem_q, rem_d;
  logic                           hex_ended_q, hex_ended_d;
  logic                           nonempty_q, nonempty_d;

  logic [2:0]                     phase_c;
  logic [hcbd_pkg::SIZE_BITS-1:0] rem_c;
  logic                           hex_ended_c;
  logic                           nonempty_c;
  logic [4:0]                     hex;
  logic                           is_lf;
  logic                           is_cr;

  assign hex   = hcbd_pkg::hex_decode(in_byte_i);
  assign is_lf = (in_byte_i == hcbd_pkg::CH_LF);
  assign is_cr = (in_byte_i == hcbd_pkg::CH_CR);

  always_comb begin
    // new_body clears the state before this byte is handled
    if (new_body_i) begin
      phase_c     = hcbd_pkg::PH_SIZE;
      rem_c       = '0;
      hex_ended_c = 1'b0;
      nonempty_c  = 1'b0;
    end else begin
      phase_c     = phase_q;
      rem_c       = rem_q;
      hex_ended_c = hex_ended_q;
      nonempty_c  = nonempty_q;
    end

    phase_d     = phase_c;
    rem_d       = rem_c;
    hex_ended_d = hex_ended_c;
    nonempty_d  = nonempty_c;
    res_o       = '0;

    unique case (phase_c)
      hcbd_pkg::PH_SIZE: begin
        if (is_lf) begin
          hex_ended_d = 1'b0;
          nonempty_d  = 1'b0;
          phase_d     = (rem_c == '0) ? hcbd_pkg::PH_TRAIL : hcbd_pkg::PH_DATA;
        end else if (!is_cr && !hex_ended_c) begin
          if (!hex[4]) begin
            hex_ended_d = 1'b1;
          end else if (rem_c[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_d    = hcbd_pkg::PH_ERROR;
            res_o.valid = 1'b1;
            res_o.kind  = hcbd_pkg::KIND_OVF;
          end else begin
            rem_d = {rem_c[hcbd_pkg::SIZE_BITS-5:0], hex[3:0]};
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        res_o.valid = 1'b1;
        res_o.kind  = hcbd_pkg::KIND_DATA;
        res_o.data  = in_byte_i;
        res_o.last  = (rem_c[hcbd_pkg::SIZE_BITS-1:1] == '0);
        if (rem_c != '0) rem_d = rem_c - {{(hcbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
        if (res_o.last) phase_d = hcbd_pkg::PH_CEND;
      end
      hcbd_pkg::PH_CEND: begin
        if (is_lf) begin
          rem_d       = '0;
          hex_ended_d = 1'b0;
          phase_d     = hcbd_pkg::PH_SIZE;
        end
      end
      hcbd_pkg::PH_TRAIL: begin
        if (is_lf) begin
          if (!nonempty_c) begin
            phase_d     = hcbd_pkg::PH_DONE;
            res_o.valid = 1'b1;
            res_o.kind  = hcbd_pkg::KIND_DONE;
          end else begin
            nonempty_d = 1'b0;
          end
        end else if (!is_cr) begin
          nonempty_d = 1'b1;
        end
      end
      default: begin
        // done, error and unused codes swallow every byte
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hcbd_pkg::PH_SIZE;
      rem_q       <= '0;
      hex_ended_q <= 1'b0;
      nonempty_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      hex_ended_q <= hex_ended_d;
      nonempty_q  <= nonempty_d;
    end
  end

endmodule

@@ rtl/core/hcbd_out_reg.sv @@
// Result register on the output channel.
module hcbd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcbd_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic [7:0]        data_byte_o,
  output logic              chunk_last_o
);

  logic              valid_q;
  hcbd_pkg::result_t res_q;

  // slot can take a new result this cycle if empty or being drained
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = res_q.kind;
  assign data_byte_o   = res_q.data;
  assign chunk_last_o  = res_q.last;

endmodule

@@ rtl/core/http_chunked_body_decoder.sv @@
// Top level of the HTTP chunked body decoder.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_byte_i, new_body_i
//   out      output     out_valid_o / out_ready_i result_kind_o, data_byte_o, chunk_last_o
//
// One byte per cycle while results can be taken: a byte is held in the input register,
// is decoded against the phase and size counter, and its result (if any) lands in the
// output register, which drives out_valid_o.
// Reset returns the decoder to the size line phase with a zero count.
// A stalled output only holds the input register when the waiting byte
// produces a result; bytes with no result keep flowing.
module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       new_body_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] data_byte_o,
  output logic       chunk_last_o
);

  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_new_q;
  logic              s1_fire;
  logic              out_free;
  hcbd_pkg::result_t res;

  assign s1_fire    = s1_valid_q && (!res.valid || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_new_q  <= new_body_i;
    end
  end

  hcbd_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .in_byte_i  (s1_byte_q),
    .new_body_i (s1_new_q),
    .res_o      (res)
  );

  hcbd_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_fire && res.valid),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .data_byte_o   (data_byte_o),
    .chunk_last_o  (chunk_last_o)
  );

endmodule

@@ rtl/core/hcbd_checker.sv @@
// Port-level checks of the chunked body decoder, bound to the top level.
module hcbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] result_kind_o,
  input logic [7:0] data_byte_o,
  input logic       chunk_last_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(data_byte_o) && $stable(chunk_last_o))
    else $error("output transaction changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o == hcbd_pkg::KIND_DATA
      || result_kind_o == hcbd_pkg::KIND_DONE || result_kind_o == hcbd_pkg::KIND_OVF))
    else $error("illegal result kind");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != hcbd_pkg::KIND_DATA |->
      data_byte_o == 8'd0 && !chunk_last_o)
    else $error("status transaction carries payload bits");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .data_byte_o   (data_byte_o),
  .chunk_last_o  (chunk_last_o)
);

@@ tb/http_chunked_body_decoder_tb.sv @@
// Self-checking testbench for the HTTP chunked body decoder: random bodies against a local model.
module http_chunked_body_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_LEN     = 150;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned N_ITEMS      = 600;

  typedef struct {
    logic [7:0]  ch;
    logic        nb;
    int unsigned gap;
  } byte_txn_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } dec_result_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte  = 8'h00;
  logic       new_body = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       chunk_last;

  http_chunked_body_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_byte_i     (in_byte),
    .new_body_i    (new_body),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind),
    .data_byte_o   (data_byte),
    .chunk_last_o  (chunk_last)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // stimulus and scoreboard storage
  byte_txn_t   body_bytes[$];
  dec_result_t pending_results[$];

  int          n_total     = 0;
  int          n_accepted  = 0;
  int          hold_at     = 32'h7fffffff;
  int          n_err       = 0;
  int          n_data      = 0;
  int          n_done      = 0;
  int          n_ovf       = 0;
  int          n_results   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cnt    = 0;
  bit          hold_done   = 1'b0;

  // generator controls
  bit          open_body   = 1'b0;
  int unsigned gap_mode    = 1;
  int          trunc_left  = -1;
  bit          counting    = 1'b0;
  int          n_gen       = 0;

  // decoder model state
  logic [2:0]                     ph;
  logic [hcbd_pkg::SIZE_BITS-1:0] remaining;
  logic                           hex_stop;
  logic                           trail_seen;

  function automatic int hex_value(logic [7:0] c);
    if (c >= hcbd_pkg::CH_ZERO && c <= hcbd_pkg::CH_NINE)
      return int'(c - hcbd_pkg::CH_ZERO);
    if (c >= hcbd_pkg::CH_LA && c <= hcbd_pkg::CH_LF_HEX)
      return int'(c - hcbd_pkg::CH_LA) + 10;
    if (c >= hcbd_pkg::CH_UA && c <= hcbd_pkg::CH_UF)
      return int'(c - hcbd_pkg::CH_UA) + 10;
    return -1;
  endfunction

  task automatic clear_decoder();
    ph         = hcbd_pkg::PH_SIZE;
    remaining  = '0;
    hex_stop   = 1'b0;
    trail_seen = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic nb);
    int          h;
    dec_result_t r;
    r = '0;
    if (nb) clear_decoder();
    case (ph)
      hcbd_pkg::PH_SIZE: begin
        if (c == hcbd_pkg::CH_LF) begin
          hex_stop   = 1'b0;
          trail_seen = 1'b0;
          ph         = (remaining == 0) ? hcbd_pkg::PH_TRAIL : hcbd_pkg::PH_DATA;
        end else if (c != hcbd_pkg::CH_CR && !hex_stop) begin
          h = hex_value(c);
          if (h < 0) begin
            hex_stop = 1'b1;
          end else if (remaining[hcbd_pkg::SIZE_BITS-1 -: 4] != 0) begin
            ph     = hcbd_pkg::PH_ERROR;
            r.kind = hcbd_pkg::KIND_OVF;
            pending_results.push_back(r);
          end else begin
            remaining = {remaining[hcbd_pkg::SIZE_BITS-5:0], h[3:0]};
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        r.kind = hcbd_pkg::KIND_DATA;
        r.data = c;
        r.last = (remaining <= 1);
        if (remaining != 0) remaining = remaining - 1'b1;
        if (r.last) ph = hcbd_pkg::PH_CEND;
        pending_results.push_back(r);
      end
      hcbd_pkg::PH_CEND: begin
        if (c == hcbd_pkg::CH_LF) begin
          remaining = '0;
          hex_stop  = 1'b0;
          ph        = hcbd_pkg::PH_SIZE;
        end
      end
      hcbd_pkg::PH_TRAIL: begin
        if (c == hcbd_pkg::CH_LF) begin
          if (!trail_seen) begin
            ph     = hcbd_pkg::PH_DONE;
            r.kind = hcbd_pkg::KIND_DONE;
            pending_results.push_back(r);
          end
          trail_seen = 1'b0;
        end else if (c != hcbd_pkg::CH_CR) begin
          trail_seen = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus builders ----------------

  task automatic put(input logic [7:0] c);
    byte_txn_t t;
    if (trunc_left == 0) return;
    if (trunc_left > 0) trunc_left--;
    t.ch  = c;
    t.nb  = open_body;
    t.gap = (gap_mode == 0) ? 0 : $urandom_range(0, 6);
    open_body = 1'b0;
    body_bytes.push_back(t);
    if (counting) n_gen++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return hcbd_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? hcbd_pkg::CH_UA : hcbd_pkg::CH_LA) + 8'(v - 10);
  endfunction

  // anything except a newline
  task automatic put_junk(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      if (c == hcbd_pkg::CH_LF) c = 8'h20;
      put(c);
    end
  endtask

  // payload biased toward line-ending characters
  task automatic put_payload(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0)
        c = $urandom_range(0, 1) ? hcbd_pkg::CH_CR : hcbd_pkg::CH_LF;
      put(c);
    end
  endtask

  task automatic put_size_line(input logic [63:0] sz);
    string       digits;
    logic [7:0]  c;
    int unsigned r;
    int unsigned nz;
    digits = $sformatf("%0h", sz);
    r  = $urandom_range(0, 9);
    nz = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 16);
    repeat (nz) put(hcbd_pkg::CH_ZERO);
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= hcbd_pkg::CH_LA && $urandom_range(0, 1))
        c = c - (hcbd_pkg::CH_LA - hcbd_pkg::CH_UA);
      put(c);
      if ($urandom_range(0, 9) == 0) put(hcbd_pkg::CH_CR);
    end
    case ($urandom_range(0, 5))
      0: put_str(";name=val");
      1: begin
        put(8'h20);
        put_junk($urandom_range(0, 6));
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
  endtask

  task automatic put_chunk(input int unsigned sz);
    put_size_line(64'(sz));
    put_payload(sz);
    case ($urandom_range(0, 5))
      0: put(hcbd_pkg::CH_LF);
      1: begin
        put_junk($urandom_range(1, 5));
        put(hcbd_pkg::CH_LF);
      end
      default: begin
        put(hcbd_pkg::CH_CR);
        put(hcbd_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic add_body();
    open_body = 1'b1;
    repeat ($urandom_range(0, 3)) begin
      put_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
    end
    put_size_line(64'd0);
    repeat ($urandom_range(0, 2)) begin
      put_junk($urandom_range(1, 6));
      put(hcbd_pkg::CH_LF);
    end
    if ($urandom_range(0, 3) != 0) put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
    // bytes after completion are dropped
    if ($urandom_range(0, 4) == 0) put_junk($urandom_range(1, 3));
  endtask

  task automatic add_overflow();
    open_body = 1'b1;
    repeat ($urandom_range(0, 2)) put(hcbd_pkg::CH_ZERO);
    put(hex_char($urandom_range(1, 15)));
    repeat ($urandom_range(10, 12)) put(hex_char($urandom_range(0, 15)));
    put_junk($urandom_range(0, 3));
  endtask

  task automatic add_big_size();
    logic [63:0] sz;
    open_body = 1'b1;
    sz = {24'h0, 8'($urandom_range(1, 255)), 32'($urandom)};
    if ($urandom_range(0, 2) == 0) sz = {24'h0, {hcbd_pkg::SIZE_BITS{1'b1}}};
    put_size_line(sz);
    put_payload($urandom_range(2, 8));
  endtask

  task automatic add_noise();
    open_body = $urandom_range(0, 1);
    repeat ($urandom_range(5, 20)) begin
      if ($urandom_range(0, 15) == 0) open_body = 1'b1;
      put(8'($urandom_range(0, 255)));
    end
  endtask

  // one long chunk sent back to back while the receiver holds off
  task automatic add_pressure_body();
    gap_mode  = 0;
    open_body = 1'b1;
    put_size_line(64'd64);
    hold_at = body_bytes.size();
    put_payload(64);
    put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
    put_size_line(64'd0);
    put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
  endtask

  // ---------------- driver ----------------

  bit          offering  = 1'b0;
  bit          gap_armed = 1'b0;
  int unsigned gap_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    byte_txn_t nxt;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_byte   <= 8'h00;
      new_body  <= 1'b0;
      offering  = 1'b0;
      gap_armed = 1'b0;
      gap_left  = 0;
      clear_decoder();
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, new_body);
        n_accepted <= n_accepted + 1;
        offering = 1'b0;
      end
      if (!offering && body_bytes.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = body_bytes[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left == 0) begin
          nxt = body_bytes.pop_front();
          in_byte   <= nxt.ch;
          new_body  <= nxt.nb;
          offering  = 1'b1;
          gap_armed = 1'b0;
        end else begin
          gap_left--;
        end
      end
      in_valid <= offering;
    end
  end

  // ---------------- receiver hold-off ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= hold_at) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // ---------------- monitor ----------------

  int unsigned stall_left = 0;
  int unsigned out_mode   = 1;

  always @(posedge clk_i or negedge rst_ni) begin
    dec_result_t got;
    dec_result_t want;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind = result_kind;
        got.data = data_byte;
        got.last = chunk_last;
        n_results++;
        case (got.kind)
          hcbd_pkg::KIND_DATA: n_data++;
          hcbd_pkg::KIND_DONE: n_done++;
          hcbd_pkg::KIND_OVF:  n_ovf++;
          default: ;
        endcase
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d data=%02h last=%0d",
                   $time, got.kind, got.data, got.last);
          n_err++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected kind=%0d data=%02h last=%0d,",
                     $time, want.kind, want.data, want.last);
            $display("%0t:   got kind=%0d data=%02h last=%0d",
                     $time, got.kind, got.data, got.last);
            n_err++;
          end
        end
        if (n_results % 32 == 0) out_mode = $urandom_range(0, 3);
        stall_left = (out_mode == 0) ? 0 : $urandom_range(0, 6);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && (hold_cnt == 0);
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d of %0d bytes accepted",
               $time, quiet_cycles, n_accepted, n_total);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    int unsigned pick;
    bit          pressure_placed;
    pressure_placed = 1'b0;

    // directed: CR inside the size line, leading zero, extreme and line-ending payload,
    // junk in the chunk end line, a non-empty then an empty trailer line,
    // a byte after completion, then an overflow and a byte in the error phase
    gap_mode  = 1;
    open_body = 1'b1;
    put(hcbd_pkg::CH_ZERO);
    put(hcbd_pkg::CH_CR);
    put("4");
    put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
    put(8'h00);
    put(8'hFF);
    put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
    put("x");
    put(hcbd_pkg::CH_LF);
    put(hcbd_pkg::CH_ZERO);
    put(hcbd_pkg::CH_LF);
    put("t");
    put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
    put(hcbd_pkg::CH_CR);
    put(hcbd_pkg::CH_LF);
    put("5");
    open_body = 1'b1;
    put("1");
    repeat (10) put(hcbd_pkg::CH_ZERO);
    put("7");

    while (n_gen < N_ITEMS) begin
      gap_mode = $urandom_range(0, 3);
      pick     = $urandom_range(0, 19);
      counting = 1'b1;
      if (!pressure_placed && n_gen >= N_ITEMS / 2) begin
        add_pressure_body();
        pressure_placed = 1'b1;
      end else if (pick < 14) begin
        add_body();
      end else if (pick == 14) begin
        trunc_left = $urandom_range(1, 30);
        add_body();
        trunc_left = -1;
      end else if (pick == 15) begin
        add_overflow();
      end else if (pick == 16) begin
        add_big_size();
      end else begin
        counting = 1'b0;
        add_noise();
      end
    end
    n_total = body_bytes.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_total || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d body bytes: %0d data bytes, %0d completed bodies, %0d size overflows.",
             n_total, n_data, n_done, n_ovf);
    $display("Both sides idled 0..6 cycles per transaction; receiver held off %0d cycles once.",
             HOLD_LEN);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ http_chunked_body_decoder.f @@
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_step.sv
rtl/core/hcbd_out_reg.sv
rtl/core/http_chunked_body_decoder.sv
rtl/core/hcbd_checker.sv
tb/http_chunked_body_decoder_tb.sv
